### rtl/aes_cbc_pkg.sv
// aes_cbc_pkg: shared types, constants and functions for the aes-256 cbc decrypt core
// holds sbox tables, gf math, the sub_word helper and the inverse round functions
// no dependencies
`timescale 1ns / 1ps
package aes_cbc_pkg;
	localparam int BlockBytes = 16;
	localparam int NumRounds  = 14;
	localparam int NumKeyHalves = 30;

	typedef enum logic [2:0] {
		REG_KEY0   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_KEY3   = 3'd3,
		REG_IV_HI  = 3'd4,
		REG_IV_LO  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ROUND = 2'd1,
		ST_DONE  = 2'd2
	} eng_state_t;

	typedef enum logic [1:0] {
		KX_IDLE = 2'd0,
		KX_RUN  = 2'd1
	} kx_state_t;

	// front to back queue entry
	typedef struct packed {
		logic [127:0] cipher;
		logic [127:0] chain;
		logic         last;
	} job_t;

	// control between key expander and engine
	typedef struct packed {
		logic busy;
	} kx_status_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] r, p;
		r = 8'h00;
		p = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) r = r ^ p;
			p = xt(p);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] blk_byte(input logic [127:0] s, input int i);
		blk_byte = s[127-8*i -: 8];
	endfunction

	// inverse shift rows followed by inverse sub bytes
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(r+4*c) -: 8] = inv_sbox(blk_byte(s, r + 4*((c + 4 - r) % 4)));
			end
		end
		inv_shift_sub = t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = blk_byte(s, 4*c);
			a1 = blk_byte(s, 4*c+1);
			a2 = blk_byte(s, 4*c+2);
			a3 = blk_byte(s, 4*c+3);
			t[127-8*(4*c)   -: 8] = gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)^gmul(a3,4'd9);
			t[127-8*(4*c+1) -: 8] = gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)^gmul(a3,4'd13);
			t[127-8*(4*c+2) -: 8] = gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)^gmul(a3,4'd11);
			t[127-8*(4*c+3) -: 8] = gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)^gmul(a3,4'd14);
		end
		inv_mix = t;
	endfunction
endpackage

### rtl/aes256_cbc_decrypt_pkcs7_core.sv
// aes256_cbc_decrypt_pkcs7_core: top level of the aes-256 cbc decryptor with pkcs7 check
// ties the front queue, round engine and key expander together
// depends on aes_cbc_pkg, aes_cbc_front, aes_cbc_back, aes_cbc_keyexp
`timescale 1ns / 1ps
// each transaction carries one 16-byte ciphertext block and gives one plaintext
// transaction. the shared inverse round unit runs one round at a time: a load
// step with the initial key add, 14 rounds, then a step that does the chain xor,
// the padding check and loads the output register; the engine finishes one block
// before it takes the next. the front queues two blocks, and a finished result
// waits in the output register while the next one runs. a key write restarts
// the key schedule in the cycle after the write; it then stays busy through one
// load step and the expansion of round keys 2 to 14, during which no new block
// enters the engine; after reset the schedule is idle and the round
// keys are undefined until a key register is written, so write all four key
// words before the first block. iv writes take effect at the next stream start.
module aes256_cbc_decrypt_pkcs7_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] ciphertext_high,
	input  logic [63:0] ciphertext_low,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] plaintext_high,
	output logic [63:0] plaintext_low,
	output logic [4:0]  byte_count,
	output logic        status,
	output logic        end_of_stream
);
	import aes_cbc_pkg::*;

	// configuration registers
	logic [63:0]  key_q [4];
	logic [63:0]  iv_hi_q, iv_lo_q;
	logic         kx_start_q;
	logic [255:0] key_now;
	job_t         job;
	logic         job_valid, job_ready;
	kx_status_t   kx_status;
	logic [3:0]   rd_round;
	logic [127:0] rd_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0]   <= '0;
			key_q[1]   <= '0;
			key_q[2]   <= '0;
			key_q[3]   <= '0;
			iv_hi_q    <= '0;
			iv_lo_q    <= '0;
			kx_start_q <= 1'b0;
		end else begin
			kx_start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY0:  begin key_q[0] <= cfg_data; kx_start_q <= 1'b1; end
					REG_KEY1:  begin key_q[1] <= cfg_data; kx_start_q <= 1'b1; end
					REG_KEY2:  begin key_q[2] <= cfg_data; kx_start_q <= 1'b1; end
					REG_KEY3:  begin key_q[3] <= cfg_data; kx_start_q <= 1'b1; end
					REG_IV_HI: iv_hi_q <= cfg_data;
					REG_IV_LO: iv_lo_q <= cfg_data;
					default:   ;
				endcase
			end
		end
	end

	assign key_now = {key_q[0], key_q[1], key_q[2], key_q[3]};

	// key schedule, restarted in the cycle after any key write
	aes_cbc_keyexp u_keyexp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kx_start_q),
		.key      (key_now),
		.rd_round (rd_round),
		.rd_key   (rd_key),
		.status   (kx_status)
	);

	// front: input handshake, chain selection, job queue
	aes_cbc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.ciphertext_high (ciphertext_high),
		.ciphertext_low  (ciphertext_low),
		.last_block      (last_block),
		.iv              ({iv_hi_q, iv_lo_q}),
		.job_valid       (job_valid),
		.job_ready       (job_ready),
		.job             (job)
	);

	// back: rounds, chain xor, padding check, output register
	aes_cbc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job_ready      (job_ready),
		.job            (job),
		.kx_status      (kx_status),
		.rd_round       (rd_round),
		.rd_key         (rd_key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.plaintext_high (plaintext_high),
		.plaintext_low  (plaintext_low),
		.byte_count     (byte_count),
		.status         (status),
		.end_of_stream  (end_of_stream)
	);
endmodule

### rtl/aes_cbc_keyexp.sv
// aes_cbc_keyexp: aes-256 key schedule, one 128-bit round key per cycle
// keeps all 15 round keys in a register file read by the round engine
// depends on aes_cbc_pkg
`timescale 1ns / 1ps
module aes_cbc_keyexp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [255:0]             key,
	input  logic [3:0]               rd_round,
	output logic [127:0]             rd_key,
	output aes_cbc_pkg::kx_status_t  status
);
	import aes_cbc_pkg::*;

	kx_state_t    state_q, state_d;
	logic [3:0]   idx_q;        // round key being produced, 2..14
	logic [255:0] win_q;        // last two round keys
	logic [7:0]   rcon_q;
	logic [127:0] rk_q [15];
	logic [31:0]  t0, w0, w1, w2, w3;
	logic [127:0] nxt;

	// even index: rotate+sub+rcon path, odd index: sub path
	always_comb begin
		if (!idx_q[0]) begin
			t0 = sub_word({win_q[23:0], win_q[31:24]}) ^ {rcon_q, 24'h0};
		end else begin
			t0 = sub_word(win_q[31:0]);
		end
		w0 = win_q[255:224] ^ t0;
		w1 = win_q[223:192] ^ w0;
		w2 = win_q[191:160] ^ w1;
		w3 = win_q[159:128] ^ w2;
		nxt = {w0, w1, w2, w3};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			KX_IDLE: if (start) state_d = KX_RUN;
			KX_RUN:  if (idx_q == 4'd14 && !start) state_d = KX_IDLE;
			default: state_d = KX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KX_IDLE;
			idx_q   <= 4'd2;
			rcon_q  <= 8'h01;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q  <= 4'd2;
				rcon_q <= 8'h01;
			end else if (state_q == KX_RUN) begin
				idx_q <= idx_q + 4'd1;
				if (!idx_q[0]) rcon_q <= xt(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			win_q  <= key;
			rk_q[0] <= key[255:128];
			rk_q[1] <= key[127:0];
		end else if (state_q == KX_RUN) begin
			win_q <= {win_q[127:0], nxt};
			rk_q[idx_q] <= nxt;
		end
	end

	assign rd_key      = rk_q[rd_round];
	assign status.busy = (state_q == KX_RUN) || start;
endmodule

### rtl/aes_cbc_front.sv
// aes_cbc_front: accepts ciphertext transactions, picks the chain block, queues jobs
// two-entry queue toward the round engine
// depends on aes_cbc_pkg
`timescale 1ns / 1ps
module aes_cbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         ciphertext_high,
	input  logic [63:0]         ciphertext_low,
	input  logic                last_block,
	input  logic [127:0]        iv,
	output logic                job_valid,
	input  logic                job_ready,
	output aes_cbc_pkg::job_t   job
);
	import aes_cbc_pkg::*;

	job_t         q_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic [127:0] chain_q;
	logic         start_q;
	logic         push, pop;
	job_t         entry;

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job       = q_q[rp_q];

	always_comb begin
		entry.cipher = {ciphertext_high, ciphertext_low};
		entry.chain  = start_q ? iv : chain_q;
		entry.last   = last_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			cnt_q   <= 2'd0;
			start_q <= 1'b1;
		end else begin
			if (push) begin
				wp_q    <= ~wp_q;
				start_q <= last_block;
			end
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= entry;
			chain_q   <= entry.cipher;
		end
	end
endmodule

### rtl/aes_cbc_back.sv
// aes_cbc_back: shared inverse round unit, chain xor, pkcs7 check, output register
// one round per cycle, reads round keys from the key expander
// depends on aes_cbc_pkg
`timescale 1ns / 1ps
module aes_cbc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  aes_cbc_pkg::job_t        job,
	input  aes_cbc_pkg::kx_status_t  kx_status,
	output logic [3:0]               rd_round,
	input  logic [127:0]             rd_key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [63:0]              plaintext_high,
	output logic [63:0]              plaintext_low,
	output logic [4:0]               byte_count,
	output logic                     status,
	output logic                     end_of_stream
);
	import aes_cbc_pkg::*;

	eng_state_t   state_q, state_d;
	logic [3:0]   rnd_q;
	logic [127:0] st_q, chain_q;
	logic         last_q;
	logic         ov_q;
	logic [127:0] pt_q;
	logic [4:0]   cnt_q;
	logic         bad_q, eos_q;
	logic         take, finish;
	logic [127:0] isb, rk_x, plain;
	logic [7:0]   pad;
	logic         bad;

	assign take   = (state_q == ST_IDLE) && job_valid && !kx_status.busy;
	assign finish = (state_q == ST_DONE) && (!ov_q || out_ready);
	assign job_ready = take;
	// round 14 key on take, then rnd_q walks down
	assign rd_round = take ? 4'd14 : rnd_q;

	always_comb begin
		isb   = inv_shift_sub(st_q);
		rk_x  = isb ^ rd_key;
		plain = st_q ^ chain_q;
		pad   = plain[7:0];
		bad   = (pad == 8'd0) || (pad > 8'd16);
		for (int i = 0; i < BlockBytes; i++) begin
			if ((i >= BlockBytes - 32'(pad)) && (blk_byte(plain, i) != pad)) bad = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 4'd0) state_d = ST_DONE;
			ST_DONE:  if (finish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= 4'd13;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) rnd_q <= 4'd13;
			else if (state_q == ST_ROUND && rnd_q != 4'd0) rnd_q <= rnd_q - 4'd1;
			if (finish) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			st_q    <= job.cipher ^ rd_key;
			chain_q <= job.chain;
			last_q  <= job.last;
		end else if (state_q == ST_ROUND) begin
			st_q <= (rnd_q == 4'd0) ? rk_x : inv_mix(rk_x);
		end
		if (finish) begin
			eos_q <= last_q;
			if (last_q && bad) begin
				pt_q  <= '0;
				cnt_q <= 5'd0;
				bad_q <= 1'b1;
			end else begin
				pt_q  <= plain;
				cnt_q <= last_q ? 5'd16 - pad[4:0] : 5'd16;
				bad_q <= 1'b0;
			end
		end
	end

	assign out_valid      = ov_q;
	assign plaintext_high = pt_q[127:64];
	assign plaintext_low  = pt_q[63:0];
	assign byte_count     = cnt_q;
	assign status         = bad_q;
	assign end_of_stream  = eos_q;
endmodule

### rtl/aes_cbc_checker.sv
// aes_cbc_checker: port-level assertions for the aes-256 cbc decrypt core
// bound to aes256_cbc_decrypt_pkcs7_core
`timescale 1ns / 1ps
module aes_cbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] plaintext_high,
	input logic [63:0] plaintext_low,
	input logic [4:0]  byte_count,
	input logic        status,
	input logic        end_of_stream
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plaintext_high)
		&& $stable(byte_count))
		else $error("output changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 5'd16)
		else $error("byte count above 16");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_stream |-> byte_count == 5'd16 && !status)
		else $error("non-final block not full");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> byte_count == 5'd0 && end_of_stream
		&& plaintext_high == 64'd0 && plaintext_low == 64'd0)
		else $error("padding error result malformed");
endmodule

bind aes256_cbc_decrypt_pkcs7_core aes_cbc_checker u_checker (.*);

### test/aes256_cbc_decrypt_pkcs7_core_tb.sv
// aes256_cbc_decrypt_pkcs7_core_tb: self-checking bench for the aes-256 cbc decrypt core
// runs directed and random streams against an in-bench inverse cipher and pkcs7 check
// depends on aes_cbc_pkg and aes256_cbc_decrypt_pkcs7_core
`timescale 1ns / 1ps
module aes256_cbc_decrypt_pkcs7_core_tb;
	import aes_cbc_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int HoldAt     = 200;   // result count at which the long receiver hold starts
	localparam int HoldLen    = 400;

	typedef logic [7:0] blk_bytes_t [16];

	// one plaintext transaction as the block should present it
	typedef struct {
		logic [63:0] pt_hi;
		logic [63:0] pt_lo;
		logic [4:0]  count;
		logic        bad_pad;
		logic        eos;
	} plain_t;

	// one ciphertext transaction waiting to be offered
	typedef struct {
		logic [63:0] ct_hi;
		logic [63:0] ct_lo;
		logic        last;
	} cipher_t;

	// directed row; typed expectation only where it is obvious
	typedef struct {
		logic [63:0] ct_hi;
		logic [63:0] ct_lo;
		logic        last;
		logic        typed;
		logic [63:0] pt_hi;
		logic [63:0] pt_lo;
		logic [4:0]  count;
		logic        bad_pad;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = REG_KEY0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] ciphertext_high = '0;
	logic [63:0] ciphertext_low = '0;
	logic        last_block = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] plaintext_high;
	logic [63:0] plaintext_low;
	logic [4:0]  byte_count;
	logic        status;
	logic        end_of_stream;

	aes256_cbc_decrypt_pkcs7_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.ciphertext_high(ciphertext_high), .ciphertext_low(ciphertext_low),
		.last_block(last_block),
		.out_valid(out_valid), .out_ready(out_ready),
		.plaintext_high(plaintext_high), .plaintext_low(plaintext_low),
		.byte_count(byte_count), .status(status), .end_of_stream(end_of_stream)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// bench copy of the block: s-boxes, key schedule, chain and config
	// ---------------------------------------------------------------
	logic [7:0]   sb_fwd [256];
	logic [7:0]   sb_inv [256];
	logic [63:0]  key_reg [4];
	logic [63:0]  iv_hi_reg, iv_lo_reg;
	logic [127:0] dec_keys [15];
	logic [127:0] prev_cipher;
	logic         at_stream_start;

	cipher_t feed_q [$];   // ciphertext transactions not yet accepted
	plain_t  plain_q [$];  // plaintext transactions still owed by the block
	int      errors = 0;
	logic    quiet = 1'b0; // no idling on either side in the closing phase

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc, p;
		acc = '0;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= p;
			p = gf_dbl(p);
		end
		return acc;
	endfunction

	// s-box from the field inverse (x^254) and the affine map
	function automatic void build_sboxes();
		logic [7:0] inv, p, y;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			if (x != 0) begin
				inv = 8'h01;
				p = x[7:0];
				for (int e = 0; e < 7; e++) begin
					p = gf_mul(p, p);
					inv = gf_mul(inv, p);
				end
			end
			y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sb_fwd[x] = y;
			sb_inv[y] = x[7:0];
		end
	endfunction

	function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
		return {sb_fwd[w[31:24]], sb_fwd[w[23:16]], sb_fwd[w[15:8]], sb_fwd[w[7:0]]};
	endfunction

	// aes-256 schedule: 60 words, 8 from the key registers
	function automatic void expand_schedule();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) begin
			w[2*i]   = key_reg[i][63:32];
			w[2*i+1] = key_reg[i][31:0];
		end
		for (int i = 8; i < 60; i++) begin
			t = w[i-1];
			if (i % 8 == 0) begin
				t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_dbl(rc);
			end else if (i % 8 == 4) begin
				t = sub_bytes32(t);
			end
			w[i] = w[i-8] ^ t;
		end
		for (int r = 0; r < 15; r++) dec_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	function automatic blk_bytes_t to_bytes(input logic [127:0] v);
		blk_bytes_t b;
		for (int i = 0; i < 16; i++) b[i] = v[127-8*i -: 8];
		return b;
	endfunction

	function automatic logic [127:0] from_bytes(input blk_bytes_t b);
		logic [127:0] v;
		for (int i = 0; i < 16; i++) v[127-8*i -: 8] = b[i];
		return v;
	endfunction

	// state byte r + 4c is row r of column c
	function automatic logic [127:0] unshift_unsub(input logic [127:0] v);
		blk_bytes_t s, t;
		s = to_bytes(v);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) t[r+4*c] = sb_inv[s[r+4*((c+4-r)%4)]];
		return from_bytes(t);
	endfunction

	function automatic logic [127:0] unmix_columns(input logic [127:0] v);
		blk_bytes_t s, t;
		s = to_bytes(v);
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				// circulant rows of 0e 0b 0d 09
				t[4*c+r] = gf_mul(s[4*c+r], 8'h0e) ^ gf_mul(s[4*c+(r+1)%4], 8'h0b)
					^ gf_mul(s[4*c+(r+2)%4], 8'h0d) ^ gf_mul(s[4*c+(r+3)%4], 8'h09);
			end
		end
		return from_bytes(t);
	endfunction

	function automatic logic [127:0] inverse_cipher(input logic [127:0] c);
		logic [127:0] s;
		s = c ^ dec_keys[14];
		for (int r = 13; r >= 1; r--) s = unmix_columns(unshift_unsub(s) ^ dec_keys[r]);
		return unshift_unsub(s) ^ dec_keys[0];
	endfunction

	// one ciphertext transaction through the bench copy; updates chain state
	function automatic plain_t predict_plain(input cipher_t ct);
		plain_t      res;
		logic [127:0] chain, pt;
		logic [7:0]  pad;
		logic        bad;
		chain = at_stream_start ? {iv_hi_reg, iv_lo_reg} : prev_cipher;
		pt = inverse_cipher({ct.ct_hi, ct.ct_lo}) ^ chain;
		prev_cipher = {ct.ct_hi, ct.ct_lo};
		at_stream_start = ct.last;
		res.count = 5'd16;
		res.bad_pad = 1'b0;
		res.eos = ct.last;
		if (ct.last) begin
			pad = pt[7:0];
			bad = (pad == 8'd0) || (pad > 8'd16);
			if (!bad)
				for (int i = 16 - pad; i < 16; i++)
					if (pt[127-8*i -: 8] != pad) bad = 1'b1;
			res.bad_pad = bad;
			res.count = bad ? 5'd0 : 5'(16 - pad);
			if (bad) pt = '0;
		end
		res.pt_hi = pt[127:64];
		res.pt_lo = pt[63:0];
		return res;
	endfunction

	function automatic void queue_block(input logic [63:0] hi, input logic [63:0] lo,
			input logic last);
		cipher_t ct;
		ct.ct_hi = hi;
		ct.ct_lo = lo;
		ct.last = last;
		feed_q.push_back(ct);
		plain_q.push_back(predict_plain(ct));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// a stream of n blocks whose final plaintext is steered: the block before the
	// last is chosen as D(last) ^ wanted, so the padding comes out as asked.
	// pad_kind 1..16 is good padding, 0 and 17..255 put that byte at the end,
	// -1 is four padding bytes with one of them off
	function automatic int queue_stream(input int n, input int pad_kind);
		logic [127:0] ct [];
		logic [127:0] want;
		ct = new[n];
		for (int i = 0; i < n; i++) ct[i] = {rand64(), rand64()};
		want = {rand64(), rand64()};
		if (pad_kind >= 1 && pad_kind <= 16) begin
			for (int i = 16 - pad_kind; i < 16; i++) want[127-8*i -: 8] = 8'(pad_kind);
		end else if (pad_kind == -1) begin
			want[31:0] = 32'h04040404 ^ (32'h1 << (8 * $urandom_range(1, 3)));
		end else begin
			want[7:0] = 8'(pad_kind);
		end
		if (n >= 2) ct[n-2] = inverse_cipher(ct[n-1]) ^ want;
		for (int i = 0; i < n; i++) queue_block(ct[i][127:64], ct[i][63:0], i == n - 1);
		return n;
	endfunction

	// ---------------------------------------------------------------
	// configuration writes, issued only with nothing in flight
	// ---------------------------------------------------------------
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
				key_reg[int'(idx)] = val;
				expand_schedule();
			end
			REG_IV_HI: iv_hi_reg = val;
			REG_IV_LO: iv_lo_reg = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (feed_q.size() != 0 || plain_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// ---------------------------------------------------------------
	// sender: offers queued ciphertext transactions, random gaps between them
	// ---------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk) begin
		logic fire;
		fire = in_valid && in_ready;
		if (fire) void'(feed_q.pop_front());
		if (!in_valid || fire) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (fire && !quiet && $urandom_range(0, 3) == 0) begin
				gap_left <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				in_valid <= 1'b1;
				ciphertext_high <= feed_q[0].ct_hi;
				ciphertext_low <= feed_q[0].ct_lo;
				last_block <= feed_q[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// long receiver hold: once HoldAt results are in, the receiver takes nothing
	// while a HoldLen countdown runs, and the core fills up
	// ---------------------------------------------------------------
	int   rx_seen = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && rx_seen >= HoldAt) begin
			hold_left <= HoldLen;
			hold_done <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// receiver: checks each plaintext transaction and stalls in bursts
	// ---------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk) begin
		plain_t want;
		logic   fire;
		fire = out_valid && out_ready;
		if (fire) begin
			if (plain_q.size() == 0) begin
				$display("%0t: unexpected plaintext transaction %h_%h", $realtime,
					plaintext_high, plaintext_low);
				errors++;
			end else begin
				want = plain_q.pop_front();
				if (plaintext_high !== want.pt_hi) begin
					$display("%0t: plaintext_high exp %h got %h", $realtime, want.pt_hi,
						plaintext_high);
					errors++;
				end
				if (plaintext_low !== want.pt_lo) begin
					$display("%0t: plaintext_low exp %h got %h", $realtime, want.pt_lo,
						plaintext_low);
					errors++;
				end
				if (byte_count !== want.count) begin
					$display("%0t: byte_count exp %0d got %0d", $realtime, want.count,
						byte_count);
					errors++;
				end
				if (status !== want.bad_pad) begin
					$display("%0t: status exp %b got %b", $realtime, want.bad_pad, status);
					errors++;
				end
				if (end_of_stream !== want.eos) begin
					$display("%0t: end_of_stream exp %b got %b", $realtime, want.eos,
						end_of_stream);
					errors++;
				end
			end
			rx_seen++;
		end
		if (hold_left != 0 || (!hold_done && rx_seen >= HoldAt)) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("aes256_cbc_decrypt_pkcs7_core_tb: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	row_t directed [6];

	initial begin
		plain_t ovr;
		int     sent;
		int     kind;
		build_sboxes();
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		iv_hi_reg = '0;
		iv_lo_reg = '0;
		expand_schedule();
		prev_cipher = '0;
		at_stream_start = 1'b1;

		// known-answer block (fips-197 aes-256 example), iv zero, stream start
		directed[0] = '{64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0, 1'b1,
			64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b0};
		// field extremes, each chained on from the block above unless that one was last
		directed[1] = '{64'h0, 64'h0, 1'b0, 1'b0, '0, '0, '0, 1'b0};
		directed[2] = '{'1, '1, 1'b1, 1'b0, '0, '0, '0, 1'b0};
		directed[3] = '{'1, '1, 1'b0, 1'b0, '0, '0, '0, 1'b0};
		directed[4] = '{64'h0, '1, 1'b0, 1'b0, '0, '0, '0, 1'b0};
		directed[5] = '{'1, 64'h0, 1'b1, 1'b0, '0, '0, '0, 1'b0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// round keys are undefined until written, so load every register first
		write_reg(REG_KEY0, 64'h0001020304050607);
		write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
		write_reg(REG_KEY2, 64'h1011121314151617);
		write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
		write_reg(REG_IV_HI, 64'h0);
		write_reg(REG_IV_LO, 64'h0);
		end_writes();

		foreach (directed[i]) begin
			queue_block(directed[i].ct_hi, directed[i].ct_lo, directed[i].last);
			if (directed[i].typed) begin
				ovr = plain_q[$];
				ovr.pt_hi = directed[i].pt_hi;
				ovr.pt_lo = directed[i].pt_lo;
				ovr.count = directed[i].count;
				ovr.bad_pad = directed[i].bad_pad;
				plain_q[$] = ovr;
			end
		end
		// good padding at both ends, then each flavor of bad padding
		void'(queue_stream(2, 1));
		void'(queue_stream(3, 16));
		void'(queue_stream(2, 0));
		void'(queue_stream(2, 17));
		void'(queue_stream(2, 255));
		void'(queue_stream(2, -1));
		// leave a stream open so the next key write lands mid-stream
		queue_block(rand64(), rand64(), 1'b0);
		drain();

		// new iv only shows at the next stream start; new key applies at once
		write_reg(REG_IV_HI, '1);
		write_reg(REG_IV_LO, '1);
		write_reg(REG_KEY2, '1);
		end_writes();
		void'(queue_stream(2, 8));
		queue_block(rand64(), rand64(), 1'b1);
		drain();

		// random phases, each under a fresh mix of register values
		for (int phase = 0; phase < 11; phase++) begin
			if (phase == 10) quiet = 1'b1;
			for (int r = 0; r < 6; r++)
				if (phase == 0 || $urandom_range(0, 2) == 0)
					write_reg(cfg_reg_t'(r), pick_value());
			end_writes();
			sent = 0;
			while (sent < 100) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					sent += queue_stream($urandom_range(2, 6), $urandom_range(1, 16));
				end else if (kind == 7) begin
					case ($urandom_range(0, 3))
						0: sent += queue_stream($urandom_range(2, 4), 0);
						1: sent += queue_stream($urandom_range(2, 4), 17);
						2: sent += queue_stream($urandom_range(2, 4), $urandom_range(18, 255));
						default: sent += queue_stream($urandom_range(2, 4), -1);
					endcase
				end else begin
					// noise: one lone block, last or not
					queue_block(rand64(), rand64(), kind == 8);
					sent++;
				end
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("aes256_cbc_decrypt_pkcs7_core_tb: done, clean");
		end else begin
			$display("aes256_cbc_decrypt_pkcs7_core_tb: done, errors");
		end
		$finish;
	end
endmodule
